### design/sai_pkg.sv
package sai_pkg;

  // field widths
  localparam int VAL_W      = 32;
  localparam int POS_W      = 4;
  localparam int FILL_W     = 5;
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 2;
  localparam int DEPTH_MAX  = 16;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DUMP   = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

endpackage

### design/sai_mem.sv
module sai_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [sai_pkg::VAL_W-1:0]      wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [sai_pkg::VAL_W-1:0]      rdata_o
);

  logic [sai_pkg::VAL_W-1:0] mem_q [DEPTH];
  logic [sai_pkg::VAL_W-1:0] rdata_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sorted_array_insert_delete.sv
// sorted table of signed 32-bit values, kept in ascending order
//
// input stream (s_axis): tuser carries the operation (insert, delete, dump),
// tdata carries the value to insert and the index to delete. one transaction
// is one operation; tready is high only while the sequencer is idle.
// output stream (m_axis): one transaction per result. insert and delete give
// one result; a dump gives one result per held entry (tlast on the final one),
// or one empty-status result if nothing is held. tuser carries the status.
//
// datapath: all work goes through a table memory with registered read, one
// access per cycle, and one signed comparator. an insert moves each larger
// entry up one slot, a delete moves each later entry down one slot, a
// refused operation or an empty dump goes straight to its result, and a dump
// reads and sends the held entries one at a time. tready rises with the
// last result.
// reset clears the fill count and all control state; table contents are not
// cleared, only slots below the fill count are ever read.
// a stalled receiver holds the output register and the sequencer waits in
// place; a finished result may sit there while the next operation is accepted.
module sorted_array_insert_delete #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] value, [35:32] position, [39:36] zero
  input  logic [sai_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // [1:0] kind
  input  logic [sai_pkg::KIND_W-1:0]         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [31:0] entry, [36:32] fill, [39:37] zero
  output logic [sai_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // [1:0] status
  output logic [sai_pkg::STAT_W-1:0]         m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  // usable slots: the table never holds more than its fixed depth
  localparam int SLOTS = (CAPACITY < sai_pkg::DEPTH_MAX) ? CAPACITY : sai_pkg::DEPTH_MAX;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = sai_pkg::FILL_W;
  localparam int VW    = sai_pkg::VAL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_DMP_RD,
    S_DMP_OUT,
    S_RES
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic signed [VW-1:0] val_q, val_d;
  sai_pkg::status_e     res_q, res_d;

  logic                 out_vld_q, out_vld_d;
  logic [VW-1:0]        out_entry_q, out_entry_d;
  logic [CW-1:0]        out_fill_q, out_fill_d;
  sai_pkg::status_e     out_stat_q, out_stat_d;
  logic                 out_last_q, out_last_d;

  logic                 in_fire;
  logic                 out_free;
  logic [VW-1:0]        in_value;
  logic [sai_pkg::POS_W-1:0] in_pos;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [VW-1:0]        mem_wdata, mem_rdata;
  logic                 greater;
  logic [CW-1:0]        idx_next;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign in_value        = s_axis_tdata_i[VW-1:0];
  assign in_pos          = s_axis_tdata_i[VW+sai_pkg::POS_W-1:VW];

  // output register is free when empty or being drained this cycle
  assign out_free = !out_vld_q || m_axis_tready_i;

  // the shared compare: does the stored entry sort after the new value
  assign greater  = $signed(mem_rdata) > val_q;
  assign idx_next = CW'(idx_q) + CW'(1);

  sai_mem #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    val_d       = val_q;
    res_d       = res_q;
    out_vld_d   = out_vld_q && !m_axis_tready_i;
    out_entry_d = out_entry_q;
    out_fill_d  = out_fill_q;
    out_stat_d  = out_stat_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          val_d = in_value;
          case (sai_pkg::kind_e'(s_axis_tuser_i))
            sai_pkg::KIND_INSERT: begin
              if (cnt_q >= CW'(SLOTS)) begin
                res_d   = sai_pkg::ST_FULL;
                state_d = S_RES;
              end else begin
                idx_d   = cnt_q[AW-1:0];
                state_d = S_INS_RD;
              end
            end
            sai_pkg::KIND_DELETE: begin
              if (CW'(in_pos) >= cnt_q) begin
                res_d   = sai_pkg::ST_RANGE;
                state_d = S_RES;
              end else begin
                idx_d   = AW'(in_pos);
                state_d = S_DEL_RD;
              end
            end
            sai_pkg::KIND_DUMP: begin
              if (cnt_q == '0) begin
                res_d   = sai_pkg::ST_EMPTY;
                state_d = S_RES;
              end else begin
                idx_d   = '0;
                state_d = S_DMP_RD;
              end
            end
            default: begin
              // unknown operation: dropped, nothing emitted
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (idx_q == '0) begin
          mem_we    = 1'b1;
          mem_wdata = val_q;
          cnt_d     = cnt_q + CW'(1);
          res_d     = sai_pkg::ST_OK;
          state_d   = S_RES;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q - AW'(1);
          state_d   = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        mem_we = 1'b1;
        if (greater) begin
          // shift the larger entry up one slot and keep walking down
          mem_wdata = mem_rdata;
          idx_d     = idx_q - AW'(1);
          state_d   = S_INS_RD;
        end else begin
          mem_wdata = val_q;
          cnt_d     = cnt_q + CW'(1);
          res_d     = sai_pkg::ST_OK;
          state_d   = S_RES;
        end
      end

      S_DEL_RD: begin
        if (idx_next >= cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          res_d   = sai_pkg::ST_OK;
          state_d = S_RES;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_next);
          state_d   = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_d     = AW'(idx_next);
        state_d   = S_DEL_RD;
      end

      S_DMP_RD: begin
        mem_re  = 1'b1;
        state_d = S_DMP_OUT;
      end

      S_DMP_OUT: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_entry_d = mem_rdata;
          out_fill_d  = cnt_q;
          out_stat_d  = sai_pkg::ST_OK;
          out_last_d  = (idx_next == cnt_q);
          if (idx_next == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = AW'(idx_next);
            state_d = S_DMP_RD;
          end
        end
      end

      S_RES: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_entry_d = '0;
          out_fill_d  = cnt_q;
          out_stat_d  = res_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_vld_q   <= 1'b0;
      idx_q       <= '0;
      val_q       <= '0;
      res_q       <= sai_pkg::ST_OK;
      out_entry_q <= '0;
      out_fill_q  <= '0;
      out_stat_q  <= sai_pkg::ST_OK;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_vld_q   <= out_vld_d;
      idx_q       <= idx_d;
      val_q       <= val_d;
      res_q       <= res_d;
      out_entry_q <= out_entry_d;
      out_fill_q  <= out_fill_d;
      out_stat_q  <= out_stat_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(sai_pkg::OUT_TDATA_W - VW - CW)'(0), out_fill_q, out_entry_q};
  assign m_axis_tuser_o  = out_stat_q;
  assign m_axis_tlast_o  = out_last_q;

  // fill count stays within the usable slots
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS))
    else $error("fill count above capacity");

  // fill count moves by at most one per cycle
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) ||
             (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("fill count jumped");

  // a full refusal reports a full table
  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stat_q == sai_pkg::ST_FULL) |-> out_fill_q == CW'(SLOTS))
    else $error("full status with table not full");

  // an empty dump reports no entries
  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stat_q == sai_pkg::ST_EMPTY) |-> out_fill_q == '0)
    else $error("empty status with entries held");

  // a dump never walks past the held entries
  a_dump_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DMP_OUT || state_q == S_DMP_RD) |-> CW'(idx_q) < cnt_q)
    else $error("dump index beyond fill count");

endmodule
